// ===== hdl/vfrs_pkg.sv =====
// shared types and constants of the vertical polyphase resampler
package vfrs_pkg;

	localparam int NUM_KERNELS = 1024;
	localparam int MAX_TAPS    = 16;
	localparam int KIDX_W      = $clog2(NUM_KERNELS);
	localparam int TIDX_W      = $clog2(MAX_TAPS);
	localparam int COEF_DEPTH  = NUM_KERNELS * MAX_TAPS;
	localparam int LEN_W       = 5;
	localparam int OFF_W       = 8;
	localparam int HDR_W       = LEN_W + OFF_W;

	localparam logic [13:0] PIXEL_MAX = 14'(16383 - 42);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TAPS);
	localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1);

	localparam logic [31:0] STEP_RESET = 32'h0001_0000;

	typedef enum logic [1:0] {
		CMD_LOAD_COEF = 2'd0,
		CMD_LOAD_HDR  = 2'd1,
		CMD_BEGIN_ROW = 2'd2,
		CMD_SAMPLE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_START_POS = 2'd0,
		CFG_POS_STEP  = 2'd1,
		CFG_KERN_BASE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_ROW   = 1'b0,
		KIND_PIXEL = 1'b1
	} kind_t;

endpackage

// ===== hdl/vfrs_mac.sv =====
// tap multiply-accumulate with saturation and final pixel clamp
module vfrs_mac (
	input  logic signed [15:0] acc,
	input  logic signed [15:0] samp,
	input  logic signed [15:0] coef,
	output logic signed [15:0] sum,
	output logic [13:0]        pixel
);

	logic signed [15:0] samp_x2;
	logic signed [31:0] prod;
	logic signed [15:0] term;
	logic signed [16:0] wide;

	assign samp_x2 = {samp[14:0], 1'b0};
	assign prod    = samp_x2 * coef;
	// high half of the product, doubled with 16-bit wrap
	assign term    = {prod[30:16], 1'b0};
	assign wide    = {acc[15], acc} + {term[15], term};

	always_comb begin
		if (wide[16] != wide[15]) begin
			sum = wide[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			sum = wide[15:0];
		end
	end

	always_comb begin
		if (sum[15]) begin
			pixel = '0;
		end else if (sum[14:0] > {1'b0, vfrs_pkg::PIXEL_MAX}) begin
			pixel = vfrs_pkg::PIXEL_MAX;
		end else begin
			pixel = sum[13:0];
		end
	end

endmodule

// ===== hdl/vertical_fir_resample_filter_top.sv =====
// vertical polyphase fir resampler: kernel tables, row sequencing and tap datapath
//
// input channel (in_valid/in_ready) takes one item per clock: coefficient
// loads, kernel header loads, row begins and samples. loads only write the
// kernel tables and give no result. a row begin gives a row report (first
// source row and tap count); a sample gives a pixel on the last tap of its kernel.
// results leave on out_valid/out_ready, held in an output register.
// configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// the user makes them while the block is idle; the block does not enforce it.
// a result passes from the tap stage, whose tables are read at the accept edge,
// into the output register, and waits in the tap stage while the receiver stalls.
// throughput: one item per clock unless a result waits on a stalled receiver;
// the coefficient and header memories are read at the accept edge and written at
// the accept edge of a load, so consecutive items never wait on the memory port.
// when the receiver stalls, the item in the tap stage holds and input ready
// drops only if that item has a result to hand over.
// reset clears row position, row count, active kernel, tap count and the
// accumulator and loads the register defaults; table contents are undefined
// until loaded, and no clearing pass is run.
module vertical_fir_resample_filter_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [1:0]                             cfg_index,
	input  logic [31:0]                            cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             cmd,
	input  logic [vfrs_pkg::KIDX_W-1:0]            kernel_index,
	input  logic [vfrs_pkg::TIDX_W-1:0]            tap_index,
	input  logic signed [15:0]                     coefficient,
	input  logic [vfrs_pkg::LEN_W-1:0]             tap_count,
	input  logic [vfrs_pkg::OFF_W-1:0]             tap_offset,
	input  logic                                   first_row,
	input  logic signed [15:0]                     sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   kind,
	output logic signed [16:0]                     source_row,
	output logic [vfrs_pkg::LEN_W-1:0]             taps_needed,
	output logic [13:0]                            pixel
);

	// configuration registers
	logic [31:0]                  start_q;
	logic [31:0]                  step_q;
	logic [vfrs_pkg::KIDX_W-1:0]  base_q;

	// row state
	logic [31:0]                  row_position_q;
	logic [9:0]                   row_number_q;
	logic [vfrs_pkg::KIDX_W-1:0]  active_kernel_q;
	logic [vfrs_pkg::TIDX_W-1:0]  tap_counter_q;
	logic [vfrs_pkg::LEN_W-1:0]   cur_len_q;
	logic signed [15:0]           acc_q;

	// kernel tables
	logic signed [15:0]              coef_mem [vfrs_pkg::COEF_DEPTH];
	logic [vfrs_pkg::HDR_W-1:0]      hdr_mem  [vfrs_pkg::NUM_KERNELS];
	logic signed [15:0]              coef_rd_q;
	logic [vfrs_pkg::HDR_W-1:0]      hdr_rd_q;

	// tap stage
	logic                 valid_s1;
	logic                 begin_s1;
	logic                 last_s1;
	logic signed [15:0]   samp_s1;
	logic [15:0]          ipos_s1;

	vfrs_pkg::cmd_t               cmd_c;
	logic                         accept;
	logic                         is_coef, is_hdr, is_begin, is_sample;
	logic [9:0]                   next_row;
	logic [31:0]                  next_pos;
	logic [vfrs_pkg::KIDX_W-1:0]  next_kernel;
	logic [vfrs_pkg::LEN_W-1:0]   len_clamped;
	logic [vfrs_pkg::LEN_W-1:0]   eff_len;
	logic [vfrs_pkg::LEN_W-1:0]   tap_plus;
	logic                         last_tap;
	logic                         result_s1;
	logic                         out_free;
	logic                         go_s1;
	logic [vfrs_pkg::LEN_W-1:0]   hdr_len;
	logic [vfrs_pkg::OFF_W-1:0]   hdr_off;
	logic signed [16:0]           srow;
	logic signed [15:0]           mac_sum;
	logic [13:0]                  mac_pixel;

	assign cfg_ready = 1'b1;
	assign cmd_c     = vfrs_pkg::cmd_t'(cmd);
	assign is_coef   = (cmd_c == vfrs_pkg::CMD_LOAD_COEF);
	assign is_hdr    = (cmd_c == vfrs_pkg::CMD_LOAD_HDR);
	assign is_begin  = (cmd_c == vfrs_pkg::CMD_BEGIN_ROW);
	assign is_sample = (cmd_c == vfrs_pkg::CMD_SAMPLE);

	assign result_s1 = begin_s1 | last_s1;
	assign out_free  = !out_valid || out_ready;
	assign go_s1     = !result_s1 || out_free;
	assign in_ready  = !valid_s1 || go_s1;
	assign accept    = in_valid && in_ready;

	assign hdr_len = hdr_rd_q[vfrs_pkg::HDR_W-1 -: vfrs_pkg::LEN_W];
	assign hdr_off = hdr_rd_q[vfrs_pkg::OFF_W-1:0];

	assign next_row    = first_row ? 10'd0 : row_number_q + 10'd1;
	assign next_pos    = first_row ? start_q : row_position_q + step_q;
	assign next_kernel = vfrs_pkg::KIDX_W'(next_row + 10'(base_q));

	always_comb begin
		if (tap_count == '0) begin
			len_clamped = vfrs_pkg::LEN_MIN;
		end else if (tap_count > vfrs_pkg::LEN_MAX) begin
			len_clamped = vfrs_pkg::LEN_MAX;
		end else begin
			len_clamped = tap_count;
		end
	end

	// a row begin in the tap stage has just fetched the new kernel length
	assign eff_len  = (valid_s1 && begin_s1) ? hdr_len : cur_len_q;
	assign tap_plus = vfrs_pkg::LEN_W'(tap_counter_q) + vfrs_pkg::LEN_W'(1);
	assign last_tap = (tap_plus >= eff_len);

	assign srow = signed'({ipos_s1[15], ipos_s1}) - signed'({9'd0, hdr_off});

	vfrs_mac u_mac (
		.acc   (acc_q),
		.samp  (samp_s1),
		.coef  (coef_rd_q),
		.sum   (mac_sum),
		.pixel (mac_pixel)
	);

	// kernel tables: write on a load, read on a row begin or a sample
	always_ff @(posedge clk) begin
		if (accept && is_coef) begin
			coef_mem[{kernel_index, tap_index}] <= coefficient;
		end
		if (accept && is_sample) begin
			coef_rd_q <= coef_mem[{active_kernel_q, tap_counter_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_hdr) begin
			hdr_mem[kernel_index] <= {len_clamped, tap_offset};
		end
		if (accept && is_begin) begin
			hdr_rd_q <= hdr_mem[next_kernel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			step_q  <= vfrs_pkg::STEP_RESET;
			base_q  <= '0;
		end else if (cfg_valid) begin
			unique case (vfrs_pkg::cfg_reg_t'(cfg_index))
				vfrs_pkg::CFG_START_POS: start_q <= cfg_data;
				vfrs_pkg::CFG_POS_STEP:  step_q  <= cfg_data;
				vfrs_pkg::CFG_KERN_BASE: base_q  <= cfg_data[vfrs_pkg::KIDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_position_q  <= '0;
			row_number_q    <= '0;
			active_kernel_q <= '0;
			tap_counter_q   <= '0;
			cur_len_q       <= '0;
		end else begin
			// a header load of the active kernel replaces the cached length
			if (accept && is_hdr && (kernel_index == active_kernel_q)) begin
				cur_len_q <= len_clamped;
			end else begin
				cur_len_q <= eff_len;
			end
			if (accept && is_begin) begin
				row_position_q  <= next_pos;
				row_number_q    <= next_row;
				active_kernel_q <= next_kernel;
				tap_counter_q   <= '0;
			end else if (accept && is_sample) begin
				tap_counter_q <= last_tap ? '0 : tap_plus[vfrs_pkg::TIDX_W-1:0];
			end
		end
	end

	// tap stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			begin_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && (is_begin || is_sample);
			begin_s1 <= accept && is_begin;
			last_s1  <= accept && is_sample && last_tap;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_s1 <= sample;
			ipos_s1 <= next_pos[31:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s1 && go_s1) begin
			if (begin_s1 || last_s1) begin
				acc_q <= '0;
			end else begin
				acc_q <= mac_sum;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (valid_s1 && result_s1 && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && result_s1 && out_free) begin
			if (begin_s1) begin
				kind        <= vfrs_pkg::KIND_ROW;
				source_row  <= srow;
				taps_needed <= hdr_len;
				pixel       <= '0;
			end else begin
				kind        <= vfrs_pkg::KIND_PIXEL;
				source_row  <= '0;
				taps_needed <= '0;
				pixel       <= mac_pixel;
			end
		end
	end

endmodule

// ===== test/vertical_fir_resample_filter_top_tb.sv =====
// self-checking testbench for the vertical polyphase fir resampler
`timescale 1ns / 1ps

module vertical_fir_resample_filter_top_tb;

	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		vfrs_pkg::cmd_t                  op;
		logic [vfrs_pkg::KIDX_W-1:0]     kidx;
		logic [vfrs_pkg::TIDX_W-1:0]     tidx;
		logic signed [15:0]              coef;
		logic [vfrs_pkg::LEN_W-1:0]      count;
		logic [vfrs_pkg::OFF_W-1:0]      offset;
		logic                            restart;
		logic signed [15:0]              smp;
	} filter_item_t;

	typedef struct {
		vfrs_pkg::kind_t                 kind;
		logic signed [16:0]              src_row;
		logic [vfrs_pkg::LEN_W-1:0]      taps;
		logic [13:0]                     pix;
	} filter_out_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [1:0]                          cfg_index;
	logic [31:0]                         cfg_data;
	logic                                in_valid;
	logic                                in_ready;
	logic [1:0]                          cmd;
	logic [vfrs_pkg::KIDX_W-1:0]         kernel_index;
	logic [vfrs_pkg::TIDX_W-1:0]         tap_index;
	logic signed [15:0]                  coefficient;
	logic [vfrs_pkg::LEN_W-1:0]          tap_count;
	logic [vfrs_pkg::OFF_W-1:0]          tap_offset;
	logic                                first_row;
	logic signed [15:0]                  sample;
	logic                                out_valid;
	logic                                out_ready;
	logic                                kind;
	logic signed [16:0]                  source_row;
	logic [vfrs_pkg::LEN_W-1:0]          taps_needed;
	logic [13:0]                         pixel;

	// predicted block state
	logic signed [15:0]                  coef_tab [vfrs_pkg::COEF_DEPTH];
	logic [vfrs_pkg::LEN_W-1:0]          len_tab [vfrs_pkg::NUM_KERNELS];
	logic [vfrs_pkg::OFF_W-1:0]          off_tab [vfrs_pkg::NUM_KERNELS];
	bit                                  coef_loaded [vfrs_pkg::COEF_DEPTH];
	bit                                  hdr_loaded [vfrs_pkg::NUM_KERNELS];
	logic [31:0]                         set_start;
	logic [31:0]                         set_step;
	logic [vfrs_pkg::KIDX_W-1:0]         set_base;
	logic [31:0]                         row_pos;
	logic [vfrs_pkg::KIDX_W-1:0]         row_cnt;
	logic [vfrs_pkg::KIDX_W-1:0]         cur_kernel;
	logic [vfrs_pkg::TIDX_W-1:0]         tap_pos;
	logic signed [15:0]                  acc_sum;

	filter_out_t               row_pixel_q [$];
	int                        fail_count;
	int                        items_sent;
	int                        rows_checked;
	int                        pixels_checked;
	int                        send_gap_max;
	int                        recv_stall_max;
	int                        hold_req;

	vertical_fir_resample_filter_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.kernel_index (kernel_index),
		.tap_index    (tap_index),
		.coefficient  (coefficient),
		.tap_count    (tap_count),
		.tap_offset   (tap_offset),
		.first_row    (first_row),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.source_row   (source_row),
		.taps_needed  (taps_needed),
		.pixel        (pixel)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// one item through the resampler: table writes, row sequencing, tap arithmetic
	function automatic void resample_step(input filter_item_t it, output bit has_res,
			output filter_out_t res);
		logic signed [15:0] w;
		logic signed [15:0] v;
		logic signed [31:0] prod;
		logic signed [16:0] sum;
		has_res = 1'b0;
		res = '{kind: vfrs_pkg::KIND_ROW, src_row: '0, taps: '0, pix: '0};
		unique case (it.op)
		vfrs_pkg::CMD_LOAD_COEF: begin
			coef_tab[{it.kidx, it.tidx}] = it.coef;
			coef_loaded[{it.kidx, it.tidx}] = 1'b1;
		end
		vfrs_pkg::CMD_LOAD_HDR: begin
			if (it.count < vfrs_pkg::LEN_MIN)
				len_tab[it.kidx] = vfrs_pkg::LEN_MIN;
			else if (it.count > vfrs_pkg::LEN_MAX)
				len_tab[it.kidx] = vfrs_pkg::LEN_MAX;
			else
				len_tab[it.kidx] = it.count;
			off_tab[it.kidx] = it.offset;
			hdr_loaded[it.kidx] = 1'b1;
		end
		vfrs_pkg::CMD_BEGIN_ROW: begin
			if (it.restart) begin
				row_cnt = '0;
				row_pos = set_start;
			end else begin
				row_cnt = row_cnt + 1'b1;
				row_pos = row_pos + set_step;
			end
			cur_kernel = row_cnt + set_base;
			tap_pos = '0;
			acc_sum = '0;
			has_res = 1'b1;
			res.kind = vfrs_pkg::KIND_ROW;
			res.src_row = {row_pos[31], row_pos[31:16]} - {9'd0, off_tab[cur_kernel]};
			res.taps = len_tab[cur_kernel];
		end
		vfrs_pkg::CMD_SAMPLE: begin
			w = coef_tab[{cur_kernel, tap_pos}];
			v = {it.smp[14:0], 1'b0};
			prod = v * w;
			// high half of the product, doubled with 16-bit wrap
			v = {prod[30:16], 1'b0};
			sum = acc_sum + v;
			if (sum > 17'sd32767)
				acc_sum = 16'sh7FFF;
			else if (sum < -17'sd32768)
				acc_sum = 16'sh8000;
			else
				acc_sum = sum[15:0];
			if ({1'b0, tap_pos} + 5'd1 >= len_tab[cur_kernel]) begin
				has_res = 1'b1;
				res.kind = vfrs_pkg::KIND_PIXEL;
				if (acc_sum[15])
					res.pix = '0;
				else if (acc_sum[14:0] > 15'(vfrs_pkg::PIXEL_MAX))
					res.pix = vfrs_pkg::PIXEL_MAX;
				else
					res.pix = acc_sum[13:0];
				tap_pos = '0;
				acc_sum = '0;
			end else begin
				tap_pos = tap_pos + 1'b1;
			end
		end
		endcase
	endfunction

	function automatic logic signed [15:0] rand16();
		unique case ($urandom_range(0, 7))
		0: return 16'sh7FFF;
		1: return 16'sh8000;
		2: return 16'sh0000;
		default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [vfrs_pkg::LEN_W-1:0] rand_count();
		if ($urandom_range(0, 3) == 0)
			return vfrs_pkg::LEN_W'($urandom_range(0, 31));
		return vfrs_pkg::LEN_W'($urandom_range(1, 4));
	endfunction

	// every field random, so the ones a command ignores still toggle
	function automatic filter_item_t random_item();
		filter_item_t it;
		it.op = vfrs_pkg::cmd_t'($urandom_range(0, 3));
		it.kidx = vfrs_pkg::KIDX_W'($urandom_range(0, vfrs_pkg::NUM_KERNELS - 1));
		it.tidx = vfrs_pkg::TIDX_W'($urandom_range(0, vfrs_pkg::MAX_TAPS - 1));
		it.coef = 16'($urandom_range(0, 65535));
		it.count = vfrs_pkg::LEN_W'($urandom_range(0, 31));
		it.offset = vfrs_pkg::OFF_W'($urandom_range(0, 255));
		it.restart = 1'($urandom_range(0, 1));
		it.smp = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	task automatic send_item(input filter_item_t it);
		int gap;
		bit has_res;
		filter_out_t res;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.op;
		kernel_index <= it.kidx;
		tap_index <= it.tidx;
		coefficient <= it.coef;
		tap_count <= it.count;
		tap_offset <= it.offset;
		first_row <= it.restart;
		sample <= it.smp;
		do @(posedge clk); while (!in_ready);
		resample_step(it, has_res, res);
		if (has_res)
			row_pixel_q.push_back(res);
		items_sent++;
	endtask

	task automatic load_coef(input logic [vfrs_pkg::KIDX_W-1:0] k,
			input logic [vfrs_pkg::TIDX_W-1:0] t, input logic signed [15:0] c);
		filter_item_t it;
		it = random_item();
		it.op = vfrs_pkg::CMD_LOAD_COEF;
		it.kidx = k;
		it.tidx = t;
		it.coef = c;
		send_item(it);
	endtask

	task automatic load_header(input logic [vfrs_pkg::KIDX_W-1:0] k,
			input logic [vfrs_pkg::LEN_W-1:0] cnt, input logic [vfrs_pkg::OFF_W-1:0] off);
		filter_item_t it;
		it = random_item();
		it.op = vfrs_pkg::CMD_LOAD_HDR;
		it.kidx = k;
		it.count = cnt;
		it.offset = off;
		send_item(it);
	endtask

	task automatic send_sample(input logic signed [15:0] s);
		filter_item_t it;
		it = random_item();
		it.op = vfrs_pkg::CMD_SAMPLE;
		it.smp = s;
		send_item(it);
	endtask

	// a kernel is read only once its header and all sixteen weights are loaded
	task automatic prepare_kernel(input logic [vfrs_pkg::KIDX_W-1:0] k);
		if (!hdr_loaded[k])
			load_header(k, rand_count(), vfrs_pkg::OFF_W'($urandom_range(0, 255)));
		for (int t = 0; t < vfrs_pkg::MAX_TAPS; t++) begin
			if (!coef_loaded[{k, vfrs_pkg::TIDX_W'(t)}])
				load_coef(k, vfrs_pkg::TIDX_W'(t), rand16());
		end
	endtask

	task automatic begin_row(input bit restart);
		filter_item_t it;
		logic [vfrs_pkg::KIDX_W-1:0] k;
		k = restart ? set_base : row_cnt + 10'd1 + set_base;
		prepare_kernel(k);
		it = random_item();
		it.op = vfrs_pkg::CMD_BEGIN_ROW;
		it.restart = restart;
		send_item(it);
	endtask

	task automatic finish_pixel();
		do send_sample(rand16()); while (tap_pos != 0);
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (row_pixel_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input vfrs_pkg::cfg_reg_t idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		unique case (idx)
		vfrs_pkg::CFG_START_POS: set_start = val;
		vfrs_pkg::CFG_POS_STEP:  set_step = val;
		vfrs_pkg::CFG_KERN_BASE: set_base = val[vfrs_pkg::KIDX_W-1:0];
		default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] start, input logic [31:0] step,
			input logic [vfrs_pkg::KIDX_W-1:0] base);
		quiesce();
		cfg_valid <= 1'b1;
		write_reg(vfrs_pkg::CFG_START_POS, start);
		write_reg(vfrs_pkg::CFG_POS_STEP, step);
		write_reg(vfrs_pkg::CFG_KERN_BASE, 32'(base));
		cfg_valid <= 1'b0;
	endtask

	// mostly whole rows of whole pixels, with stray loads, samples and row begins
	task automatic run_random(input int n);
		int stop_at;
		int pick;
		int rows_in_frame;
		stop_at = items_sent + n;
		rows_in_frame = 0;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				load_coef(vfrs_pkg::KIDX_W'($urandom_range(0, vfrs_pkg::NUM_KERNELS - 1)),
					vfrs_pkg::TIDX_W'($urandom_range(0, vfrs_pkg::MAX_TAPS - 1)),
					rand16());
			end else if (pick < 10) begin
				load_header(vfrs_pkg::KIDX_W'($urandom_range(0, vfrs_pkg::NUM_KERNELS - 1)),
					rand_count(), vfrs_pkg::OFF_W'($urandom_range(0, 255)));
			end else if (pick < 14) begin
				send_sample(rand16());
			end else if (pick < 17) begin
				begin_row(1'($urandom_range(0, 1)));
			end else begin
				if (rows_in_frame >= 6 || $urandom_range(0, 5) == 0) begin
					begin_row(1'b1);
					rows_in_frame = 0;
				end else begin
					begin_row(1'b0);
					rows_in_frame++;
				end
				repeat ($urandom_range(1, 4)) finish_pixel();
				// cut the next pixel short
				if ($urandom_range(0, 9) == 0)
					send_sample(rand16());
			end
		end
	endtask

	task automatic compare_output();
		filter_out_t due;
		if (row_pixel_q.size() == 0) begin
			$error("output with nothing due: kind %0d source_row %0d taps_needed %0d pixel %0d",
				kind, source_row, taps_needed, pixel);
			fail_count++;
		end else begin
			due = row_pixel_q.pop_front();
			if (kind !== due.kind) begin
				$error("kind: expected %0d, got %0d", due.kind, kind);
				fail_count++;
			end
			if (source_row !== due.src_row) begin
				$error("source_row: expected %0d, got %0d", due.src_row, source_row);
				fail_count++;
			end
			if (taps_needed !== due.taps) begin
				$error("taps_needed: expected %0d, got %0d", due.taps, taps_needed);
				fail_count++;
			end
			if (pixel !== due.pix) begin
				$error("pixel: expected %0d, got %0d", due.pix, pixel);
				fail_count++;
			end
			if (due.kind == vfrs_pkg::KIND_ROW)
				rows_checked++;
			else
				pixels_checked++;
		end
	endtask

	initial begin : output_side
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				compare_output();
				stall_left = $urandom_range(0, recv_stall_max);
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic test_directed_cases();
		// kernel 0 serves samples before any row: two taps, extreme weights
		load_header(0, 5'd2, 8'd0);
		load_coef(0, 0, 16'sh7FFF);
		load_coef(0, 1, 16'sh8000);
		prepare_kernel(0);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		// zero tap count held at one, so every sample ends a pixel
		load_header(0, 5'd0, 8'd255);
		send_sample(16'sh4000);
		send_sample(16'sh0000);
		// count above the maximum held at sixteen
		load_header(1, 5'd31, 8'd255);
		// advance before any restart lands on kernel 1
		begin_row(1'b0);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		// restart mid-pixel clears the taps and the sum
		begin_row(1'b1);
		send_sample(16'sh7FFF);
		load_header(0, 5'd16, 8'd0);
		begin_row(1'b1);
		finish_pixel();
	endtask

	task automatic test_position_extremes();
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023);
		run_random(220);
	endtask

	task automatic test_zero_position();
		set_config(32'h0000_0000, 32'h0000_0000, 10'd0);
		run_random(150);
	endtask

	task automatic test_random_settings();
		set_config($urandom, $urandom_range(0, 32'h0004_0000),
			vfrs_pkg::KIDX_W'($urandom_range(0, 1023)));
		run_random(150);
		set_config($urandom, $urandom, vfrs_pkg::KIDX_W'($urandom_range(0, 1023)));
		run_random(150);
	endtask

	task automatic test_back_to_back();
		send_gap_max = 0;
		recv_stall_max = 0;
		set_config($urandom, vfrs_pkg::STEP_RESET, vfrs_pkg::KIDX_W'($urandom_range(0, 1023)));
		run_random(150);
		send_gap_max = 18;
		recv_stall_max = 18;
	endtask

	task automatic test_output_backpressure();
		set_config(32'h0008_0000, 32'h0001_8000, 10'd5);
		send_gap_max = 0;
		recv_stall_max = 2;
		hold_req = 300;
		run_random(120);
		send_gap_max = 18;
		recv_stall_max = 18;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= vfrs_pkg::CFG_START_POS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= vfrs_pkg::CMD_SAMPLE;
		kernel_index <= '0;
		tap_index <= '0;
		coefficient <= '0;
		tap_count <= '0;
		tap_offset <= '0;
		first_row <= 1'b0;
		sample <= '0;
		set_start = '0;
		set_step = vfrs_pkg::STEP_RESET;
		set_base = '0;
		row_pos = '0;
		row_cnt = '0;
		cur_kernel = '0;
		tap_pos = '0;
		acc_sum = '0;
		fail_count = 0;
		items_sent = 0;
		rows_checked = 0;
		pixels_checked = 0;
		send_gap_max = 18;
		recv_stall_max = 18;
		hold_req = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_position_extremes();
		test_zero_position();
		test_random_settings();
		test_back_to_back();
		test_output_backpressure();
		quiesce();

		$display("%0d items sent, %0d row reports and %0d pixels compared, %0d mismatches",
			items_sent, rows_checked, pixels_checked, fail_count);
		$display("covered: reset, extreme, zero and random positions; paced, gapless, long stall");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/vfrs_pkg.sv
hdl/vfrs_mac.sv
hdl/vertical_fir_resample_filter_top.sv
test/vertical_fir_resample_filter_top_tb.sv
